// ===== design/pgsd_pkg.sv =====
package pgsd_pkg;

	// field widths of the stream words
	localparam int RegionPtW   = 10;
	localparam int EtaIndexW   = 5;
	localparam int GroupIndexW = 5;
	localparam int SigmaW      = 15;

	// accumulator widths
	localparam int SumW = 15;
	localparam int SqW  = 26;

	typedef struct packed {
		logic [RegionPtW-1:0] region_pt;
		logic [EtaIndexW-1:0] eta_index;
		logic                 event_end;
	} in_word_t;

	typedef struct packed {
		logic [GroupIndexW-1:0] group_index;
		logic [SigmaW-1:0]      sigma_q4;
		logic                   last_group;
	} out_word_t;

	// one accumulator entry
	typedef struct packed {
		logic [SumW-1:0] sum;
		logic [SqW-1:0]  sum_sq;
	} acc_entry_t;

endpackage

// ===== design/pgsd_stream_if.sv =====
interface pgsd_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/pgsd_isqrt.sv =====
module pgsd_isqrt #(
	parameter int XW = 41,
	parameter int RW = 21
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [XW-1:0] operand,
	output logic          busy,
	output logic [RW-1:0] root
);
	localparam int CntW = $clog2(RW + 1);

	logic [2*RW-1:0] x_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;

	logic [RW+2:0] rem_sh;
	logic [RW+2:0] trial;
	logic [RW+2:0] diff;
	logic          fits;

	// one root bit per cycle, two operand bits shifted in
	always_comb begin
		rem_sh = {rem_q, x_q[2*RW-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		diff   = rem_sh - trial;
		fits   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CntW'(1);
			if (cnt_q == CntW'(RW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= (2*RW)'(operand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= fits ? (RW+1)'(diff) : (RW+1)'(rem_sh);
			root_q <= {root_q[RW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// ===== design/per_group_standard_deviation.sv =====
// per-group standard deviation over eta rings, sigma in q.4
// each word: memory read, then saturating add and write back
// an end-of-event word starts the emit, paced by the bit-serial square root,
// one result word per group
// reset (arst_n, async) clears all sums via per-entry valid bits, no sweep needed
module per_group_standard_deviation #(
	parameter int GROUPS    = 22,
	parameter int RING_SIZE = 18,
	parameter int PT_BITS   = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pgsd_stream_if.sink           in_stream,
	pgsd_stream_if.source         out_stream
);
	import pgsd_pkg::*;

	// group address and range compare widths (eta_index up to 31, GROUPS up to 64)
	localparam int GrpW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int CmpW = 7;

	// only the low PT_BITS of region_pt count
	localparam int PtW = (PT_BITS < RegionPtW) ? PT_BITS : RegionPtW;
	localparam logic [RegionPtW-1:0] PtMask = RegionPtW'((32'd1 << PtW) - 1);
	localparam int PtSqW = 2 * RegionPtW;

	// variance numerator: ring*S2 - S*S
	localparam int AW = SqW + $clog2(RING_SIZE);
	localparam int BW = 2 * SumW;
	localparam int DW = (AW > BW) ? AW : BW;
	localparam int XW = DW + 8;
	localparam int RootW = (XW + 1) / 2;

	// floor(root / ring) by reciprocal, exact for every root below 2^RootW
	localparam int RingW = $clog2(RING_SIZE + 1);
	localparam int RecK = RootW + RingW;
	localparam int RecW = RecK + 1;
	localparam logic [RecW-1:0] RecM =
		RecW'(((64'd1 << RecK) + 64'(RING_SIZE) - 64'd1) / 64'(RING_SIZE));
	localparam int ProdW = RootW + RecW;
	localparam logic [RootW-1:0] SigmaMax = RootW'((32'd1 << SigmaW) - 1);

	typedef enum logic [3:0] {
		ST_IDLE,  // take a word, memory read in flight
		ST_RMW,   // read data back, saturating add, write back
		ST_RD,    // emit: read group entry
		ST_MUL,   // emit: ring*S2 and S*S
		ST_SUB,   // emit: clamp difference, launch square root
		ST_SQRT,  // emit: wait for the root
		ST_DIV,   // emit: multiply by reciprocal of ring size
		ST_SAT,   // emit: saturate into the output register
		ST_OUT    // emit: hold result word until taken
	} state_t;

	state_t state_q;

	// accumulator memory, one entry per group
	acc_entry_t mem_q [GROUPS];
	acc_entry_t rdata_q;
	acc_entry_t wdata;
	logic [GrpW-1:0] rd_addr;
	logic            mem_we;

	// entries not valid read as zero (reset and after each emit)
	logic [GROUPS-1:0] vld_q;

	// captured input word
	logic [RegionPtW-1:0] pt_q;
	logic [PtSqW-1:0]     ptsq_q;
	logic [GrpW-1:0]      addr_q;
	logic                 hit_q;
	logic                 end_q;

	// emit datapath
	logic [GrpW-1:0]  gcnt_q;
	logic [AW-1:0]    a_q;
	logic [BW-1:0]    b_q;
	logic [ProdW-1:0] prod_q;

	logic [RegionPtW-1:0] pt_in;
	logic                 hit_in;
	logic                 in_acc;
	logic                 out_acc;
	logic                 last_grp;

	logic [SumW-1:0]  cur_sum;
	logic [SqW-1:0]   cur_sq;
	logic [SumW:0]    sum_new;
	logic [SqW:0]     sq_new;
	logic [DW-1:0]    diff;
	logic [XW-1:0]    sq_operand;
	logic             sqrt_start;
	logic             sqrt_busy;
	logic [RootW-1:0] sqrt_root;
	logic [RootW-1:0] quot;

	out_word_t out_word_q;
	logic      out_valid_q;

	assign in_acc  = in_stream.valid && in_stream.ready;
	assign out_acc = out_valid_q && out_stream.ready;
	assign in_stream.ready  = (state_q == ST_IDLE);
	assign out_stream.valid = out_valid_q;
	assign out_stream.data  = out_word_q;

	assign pt_in  = in_stream.data.region_pt & PtMask;
	assign hit_in = (CmpW'(in_stream.data.eta_index) < CmpW'(GROUPS));

	assign last_grp = (gcnt_q == GrpW'(GROUPS - 1));

	// read port follows the input word while idle, the group counter otherwise
	assign rd_addr = (state_q == ST_IDLE) ? GrpW'(in_stream.data.eta_index) : gcnt_q;

	// entry as seen after clearing
	always_comb begin
		if (state_q == ST_RMW) begin
			cur_sum = vld_q[addr_q] ? rdata_q.sum : '0;
			cur_sq  = vld_q[addr_q] ? rdata_q.sum_sq : '0;
		end else begin
			cur_sum = vld_q[gcnt_q] ? rdata_q.sum : '0;
			cur_sq  = vld_q[gcnt_q] ? rdata_q.sum_sq : '0;
		end
	end

	// saturating accumulate
	always_comb begin
		sum_new = (SumW+1)'(cur_sum) + (SumW+1)'(pt_q);
		sq_new  = (SqW+1)'(cur_sq) + (SqW+1)'(ptsq_q);
		wdata.sum    = sum_new[SumW] ? '1 : sum_new[SumW-1:0];
		wdata.sum_sq = sq_new[SqW] ? '1 : sq_new[SqW-1:0];
		mem_we = (state_q == ST_RMW) && hit_q;
	end

	// negative variance (from saturated sums or more than RING_SIZE regions in a ring) clamps to zero
	assign diff       = (DW'(a_q) > DW'(b_q)) ? (DW'(a_q) - DW'(b_q)) : '0;
	assign sq_operand = {diff, 8'h00};
	assign sqrt_start = (state_q == ST_SUB);
	assign quot       = prod_q[RecK +: RootW];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[addr_q] <= wdata;
		end
		rdata_q <= mem_q[rd_addr];
	end

	pgsd_isqrt #(
		.XW (XW),
		.RW (RootW)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.operand (sq_operand),
		.busy    (sqrt_busy),
		.root    (sqrt_root)
	);

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pt_q   <= pt_in;
			ptsq_q <= PtSqW'(pt_in) * PtSqW'(pt_in);
			addr_q <= GrpW'(in_stream.data.eta_index);
			hit_q  <= hit_in;
			end_q  <= in_stream.data.event_end;
		end
		if (state_q == ST_MUL) begin
			a_q <= AW'(cur_sq) * AW'(RING_SIZE);
			b_q <= BW'(cur_sum) * BW'(cur_sum);
		end
		if (state_q == ST_DIV) begin
			prod_q <= ProdW'(sqrt_root) * ProdW'(RecM);
		end
		if (state_q == ST_SAT) begin
			out_word_q.group_index <= GroupIndexW'(gcnt_q);
			out_word_q.sigma_q4    <= (quot > SigmaMax) ? SigmaW'(SigmaMax) : SigmaW'(quot);
			out_word_q.last_group  <= last_grp;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			gcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_RMW;
					end
				end
				ST_RMW: begin
					if (hit_q) begin
						vld_q[addr_q] <= 1'b1;
					end
					gcnt_q  <= '0;
					state_q <= end_q ? ST_RD : ST_IDLE;
				end
				ST_RD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// entry is consumed: clear it for the next event
					vld_q[gcnt_q] <= 1'b0;
					state_q       <= ST_SUB;
				end
				ST_SUB: begin
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (!sqrt_busy) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (last_grp) begin
							state_q <= ST_IDLE;
						end else begin
							gcnt_q  <= gcnt_q + GrpW'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== test/tb_per_group_standard_deviation.sv =====
`timescale 1ns / 1ps

import pgsd_pkg::*;

// block configuration as built, no registers to write
localparam int GROUPS    = 22;
localparam int RING_SIZE = 18;
localparam int PT_BITS   = 10;

localparam longint unsigned SUM_MAX   = (64'd1 << SumW) - 1;
localparam longint unsigned SQ_MAX    = (64'd1 << SqW) - 1;
localparam longint unsigned SIGMA_MAX = (64'd1 << SigmaW) - 1;
localparam longint unsigned PT_MASK   = (64'd1 << PT_BITS) - 1;

// tracks the per-ring sums and the sigma words each event end owes
class ring_sigma_tracker;
	longint unsigned ring_sum[GROUPS];
	longint unsigned ring_sum_sq[GROUPS];
	out_word_t       sigma_due[$];
	int              mismatches;
	int              words_checked;
	int              events_closed;
	int              regions_seen;
	int              sat_hits;
	int              clamp_hits;

	function longint unsigned floor_root(longint unsigned v);
		longint unsigned root;
		longint unsigned probe;
		root  = 0;
		probe = 64'h4000_0000_0000_0000;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v    = v - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function longint unsigned sigma_q4_of(longint unsigned s, longint unsigned s2);
		longint unsigned scaled_sq;
		longint unsigned sq_of_sum;
		longint unsigned spread;
		longint unsigned q;
		scaled_sq = RING_SIZE * s2;
		sq_of_sum = s * s;
		if (sq_of_sum > scaled_sq)
			clamp_hits++;
		spread = (scaled_sq > sq_of_sum) ? scaled_sq - sq_of_sum : 0;
		q      = floor_root(spread << 8) / RING_SIZE;
		return (q > SIGMA_MAX) ? SIGMA_MAX : q;
	endfunction

	function void note_region(in_word_t w);
		longint unsigned pt;
		longint unsigned s;
		longint unsigned s2;
		out_word_t       want;
		int              g;
		regions_seen++;
		pt = longint'(w.region_pt) & PT_MASK;
		if (w.eta_index < GROUPS) begin
			s  = ring_sum[w.eta_index] + pt;
			s2 = ring_sum_sq[w.eta_index] + pt * pt;
			if (s > SUM_MAX || s2 > SQ_MAX)
				sat_hits++;
			ring_sum[w.eta_index]    = (s > SUM_MAX) ? SUM_MAX : s;
			ring_sum_sq[w.eta_index] = (s2 > SQ_MAX) ? SQ_MAX : s2;
		end
		if (!w.event_end)
			return;
		events_closed++;
		for (g = 0; g < GROUPS; g++) begin
			want.group_index = g[GroupIndexW-1:0];
			want.sigma_q4    = SigmaW'(sigma_q4_of(ring_sum[g], ring_sum_sq[g]));
			want.last_group  = (g == GROUPS - 1);
			sigma_due.push_back(want);
			ring_sum[g]    = 0;
			ring_sum_sq[g] = 0;
		end
	endfunction

	function void check_sigma_word(out_word_t got);
		out_word_t want;
		words_checked++;
		if (sigma_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected sigma word: group %0d sigma %0d last %0b",
					got.group_index, got.sigma_q4, got.last_group);
			return;
		end
		want = sigma_due.pop_front();
		if (got.group_index !== want.group_index || got.sigma_q4 !== want.sigma_q4 ||
				got.last_group !== want.last_group) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("sigma word %0d mismatch: expected group %0d sigma %0d last %0b,",
					words_checked, want.group_index, want.sigma_q4, want.last_group);
				$display("    got group %0d sigma %0d last %0b",
					got.group_index, got.sigma_q4, got.last_group);
			end
		end
	endfunction
endclass

module tb_per_group_standard_deviation;

	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int RANDOM_REGIONS = 210;
	localparam int TAIL_CYCLES    = 64;
	localparam int QUIET_REGIONS  = 40;

	logic clk;
	logic arst_n;

	// region words in, sigma words out
	pgsd_stream_if #(.word_t(in_word_t))  in_if ();
	pgsd_stream_if #(.word_t(out_word_t)) out_if ();

	per_group_standard_deviation #(
		.GROUPS    (GROUPS),
		.RING_SIZE (RING_SIZE),
		.PT_BITS   (PT_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_stream  (in_if),
		.out_stream (out_if)
	);

	ring_sigma_tracker tracker = new;

	int cycle_count  = 0;
	int regions_sent = 0;
	int gap_pct      = 0;   // sender idle chance per word, picked per event
	bit quiet        = 0;   // no idling on either side near the end

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d sigma words still due",
				cycle_count, tracker.sigma_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// sigma words are checked at the edge where they are taken
	always @(posedge clk) begin
		if (arst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
			tracker.check_sigma_word(out_if.data);
	end

	// receiver back-pressure: random bursts of stalled cycles, stall rate
	// re-picked now and then so some stretches never stall
	initial begin
		int stall_left;
		int stall_pct;
		stall_left = 0;
		stall_pct  = 0;
		out_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (cycle_count % 97 == 0)
				case ($urandom_range(2, 0))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 35;
				endcase
			if (stall_left > 0) begin
				stall_left--;
				out_if.ready <= 1'b0;
			end else if (!quiet && $urandom_range(99, 0) < stall_pct) begin
				stall_left = $urandom_range(14, 1) - 1;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	// one region word; valid stays up until the block takes it
	task automatic send_region(input logic [RegionPtW-1:0] pt,
			input logic [EtaIndexW-1:0] eta, input logic last);
		in_word_t w;
		int       gap;
		w.region_pt = pt;
		w.eta_index = eta;
		w.event_end = last;
		@(negedge clk);
		if (!quiet && $urandom_range(99, 0) < gap_pct) begin
			gap = $urandom_range(14, 1);
			in_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data  <= w;
		do
			@(posedge clk);
		while (in_if.ready !== 1'b1);
		tracker.note_region(w);
		regions_sent++;
	endtask

	// drop valid and hold until every owed sigma word has come back
	task automatic drain_sigmas();
		@(negedge clk);
		in_if.valid <= 1'b0;
		while (tracker.sigma_due.size() != 0)
			@(posedge clk);
	endtask

	// full-scale and zero come up often, the rest uniform
	function automatic logic [RegionPtW-1:0] pick_pt();
		case ($urandom_range(7, 0))
			0: return '0;
			1: return '1;
			default: return RegionPtW'($urandom_range(1023, 0));
		endcase
	endfunction

	initial begin
		int kind;
		int n;
		int i;
		int g;
		int base;
		int random_end;

		in_if.valid  <= 1'b0;
		in_if.data   <= '0;
		arst_n       <= 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part
		// event end on an empty accumulator: every ring reports zero
		send_region(10'd0, 5'd0, 1'b1);
		// extremes on the first and last ring, middle ring, then words whose
		// group is out of range; the last of them still closes the event
		send_region(10'd1023, 5'd0, 1'b0);
		send_region(10'd0, 5'd0, 1'b0);
		send_region(10'd1023, 5'd21, 1'b0);
		send_region(10'd1, 5'd21, 1'b0);
		send_region(10'd512, 5'd10, 1'b0);
		send_region(10'd1023, 5'd22, 1'b0);
		send_region(10'd1023, 5'd31, 1'b0);
		send_region(10'd777, 5'd31, 1'b1);
		// single full-scale region closing its own event
		send_region(10'd1023, 5'd5, 1'b1);
		// two equal regions in one ring
		send_region(10'd1023, 5'd3, 1'b0);
		send_region(10'd1023, 5'd3, 1'b1);
		// alternating bit patterns in pt and index
		send_region(10'h2aa, 5'h15, 1'b0);
		send_region(10'h155, 5'h0a, 1'b1);

		// sender waits for the whole emit before going on
		drain_sigmas();

		random_end = regions_sent + RANDOM_REGIONS;

		// one ring driven past both saturation points
		gap_pct = 15;
		g = $urandom_range(GROUPS - 1, 0);
		n = 68;
		for (i = 0; i < n; i++)
			send_region(RegionPtW'($urandom_range(1023, 1010)), EtaIndexW'(g), i == n - 1);

		// random events, mostly well formed, some noise and broken ones
		while (regions_sent < random_end) begin
			quiet = (regions_sent >= random_end - QUIET_REGIONS);
			case ($urandom_range(2, 0))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 50;
			endcase
			kind = $urandom_range(99, 0);
			if (kind < 8) begin
				// stray word, any index, rarely an event end
				send_region(pick_pt(), EtaIndexW'($urandom_range(31, 0)),
					$urandom_range(7, 0) == 0);
			end else if (kind < 78) begin
				// ordinary event, now and then a region outside the rings
				n = $urandom_range(30, 1);
				for (i = 0; i < n; i++)
					send_region(pick_pt(),
						EtaIndexW'(($urandom_range(19, 0) == 0) ?
							$urandom_range(31, GROUPS) :
							$urandom_range(GROUPS - 1, 0)),
						i == n - 1);
			end else if (kind < 90) begin
				// crowded ring: more than RING_SIZE near-equal regions, so
				// the variance estimate goes negative and is clamped
				g    = $urandom_range(GROUPS - 1, 0);
				base = $urandom_range(1020, 3);
				n    = $urandom_range(26, RING_SIZE + 1);
				for (i = 0; i < n; i++)
					send_region(RegionPtW'(base - 3 + $urandom_range(6, 0)),
						EtaIndexW'(g), i == n - 1);
			end else begin
				// broken event: end mark rides on an out-of-range word
				n = $urandom_range(8, 1);
				for (i = 0; i < n; i++)
					send_region(pick_pt(), EtaIndexW'($urandom_range(GROUPS - 1, 0)), 1'b0);
				send_region(pick_pt(), EtaIndexW'($urandom_range(31, GROUPS)), 1'b1);
			end
		end

		drain_sigmas();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d region words over %0d events, %0d sigma words compared",
			tracker.regions_seen, tracker.events_closed, tracker.words_checked);
		$display("saturating adds %0d, clamped variances %0d, mismatches %0d",
			tracker.sat_hits, tracker.clamp_hits, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.sigma_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
